### rtl/av_sync_pkg.sv
// av_sync_pkg: shared types and operation codes for the a/v sync media clock
// no dependencies; imported by av_sync_media_clock
`default_nettype none

package av_sync_pkg;

    localparam int unsigned STAMP_W = 64;

    typedef logic signed [STAMP_W-1:0] stamp_t;

    // operation codes carried by each input transfer; code 3 is unused
    typedef enum logic [1:0] {
        OP_AUDIO   = 2'd0,
        OP_VIDEO   = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    localparam stamp_t STAMP_UNSET = '0;

endpackage

`default_nettype wire

### rtl/av_sync_media_clock.sv
// av_sync_media_clock: a/v presentation sync clock, one transfer per cycle while not stalled
// depends on av_sync_pkg (stamp and opcode types)
`default_nettype none

// Audio/video presentation sync clock. Each input transfer carries an opcode
// (audio timestamp update, video timestamp update or clock restart), the
// frame timestamp and the current wall time, all in microseconds. Each input
// transfer gives exactly one output transfer: the signed lead of the frame
// over the media clock (delay_us) and the last audio timestamp seen
// (audio_position_us). The first timestamp of either stream anchors the base
// time (now - stamp); when the other stream starts later with a larger first
// stamp the base is pulled back by the difference. A base of zero counts as
// unset, and a last audio stamp of zero counts as no audio. Restart clears all
// state and reports zeros; the unused opcode reports a zero delay and leaves
// the state alone. All arithmetic wraps modulo 2^64, compares are signed.
// Timing: an accepted transfer is held in the input register, and its result
// goes into the output register once that register is free; throughput is one
// transfer per cycle while out_stall stays low. The state update and the result
// come from one pass of 64-bit subtract/compare logic behind the input register.
module av_sync_media_clock (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input channel
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire logic [1:0]          opcode,
    input  wire av_sync_pkg::stamp_t timestamp_us,
    input  wire av_sync_pkg::stamp_t now_us,
    // output channel
    output      logic                out_valid,
    input  wire logic                out_stall,
    output      av_sync_pkg::stamp_t delay_us,
    output      av_sync_pkg::stamp_t audio_position_us
);
    import av_sync_pkg::*;

    // input register
    logic       s1_valid_reg;
    logic [1:0] s1_op_reg;
    stamp_t     s1_ts_reg;
    stamp_t     s1_now_reg;

    // clock state
    logic   audio_started_reg, audio_started_next;
    logic   video_started_reg, video_started_next;
    stamp_t last_audio_reg,    last_audio_next;
    stamp_t first_audio_reg,   first_audio_next;
    stamp_t first_video_reg,   first_video_next;
    stamp_t base_reg,          base_next;

    // output register
    logic   out_valid_reg;
    stamp_t delay_reg,  delay_next;
    stamp_t pos_reg,    pos_next;

    logic   out_free;
    logic   s1_fire;
    logic   in_fire;
    stamp_t elapsed;      // now - base, the running media time
    stamp_t anchor;       // base for a first stamp when base is unset

    // handshake: output register takes a result when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign elapsed = s1_now_reg - base_reg;
    assign anchor  = s1_now_reg - s1_ts_reg;

    // one pass: state update and result for the item in the input register
    always_comb
    begin
        audio_started_next = audio_started_reg;
        video_started_next = video_started_reg;
        last_audio_next    = last_audio_reg;
        first_audio_next   = first_audio_reg;
        first_video_next   = first_video_reg;
        base_next          = base_reg;
        delay_next         = '0;
        pos_next           = last_audio_reg;
        case (s1_op_reg)
            OP_AUDIO:
            begin
                last_audio_next = s1_ts_reg;
                pos_next        = s1_ts_reg;
                if (!audio_started_reg)
                begin
                    // first audio stamp: media time equals the stamp, lead is zero
                    audio_started_next = 1'b1;
                    first_audio_next   = s1_ts_reg;
                    if (base_reg == STAMP_UNSET)
                        base_next = anchor;
                    else if (s1_ts_reg > first_video_reg)
                        base_next = base_reg - (s1_ts_reg - first_video_reg);
                end
                else
                begin
                    delay_next = s1_ts_reg - elapsed;
                end
            end
            OP_VIDEO:
            begin
                if (!video_started_reg)
                begin
                    video_started_next = 1'b1;
                    first_video_next   = s1_ts_reg;
                    if (base_reg == STAMP_UNSET)
                        base_next = anchor;
                    else if (s1_ts_reg > first_audio_reg)
                        base_next = base_reg - (s1_ts_reg - first_audio_reg);
                end
                // prefer the audio stamp as reference, else the media time after the first video
                if (last_audio_reg != STAMP_UNSET)
                    delay_next = s1_ts_reg - last_audio_reg;
                else if (video_started_reg)
                    delay_next = s1_ts_reg - elapsed;
                else
                    delay_next = '0;
            end
            OP_RESTART:
            begin
                audio_started_next = 1'b0;
                video_started_next = 1'b0;
                last_audio_next    = '0;
                first_audio_next   = '0;
                first_video_next   = '0;
                base_next          = STAMP_UNSET;
                pos_next           = '0;
            end
            default:
            begin
                delay_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            audio_started_reg <= 1'b0;
            video_started_reg <= 1'b0;
            last_audio_reg    <= '0;
            first_audio_reg   <= '0;
            first_video_reg   <= '0;
            base_reg          <= STAMP_UNSET;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                audio_started_reg <= audio_started_next;
                video_started_reg <= video_started_next;
                last_audio_reg    <= last_audio_next;
                first_audio_reg   <= first_audio_next;
                first_video_reg   <= first_video_next;
                base_reg          <= base_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg  <= opcode;
            s1_ts_reg  <= timestamp_us;
            s1_now_reg <= now_us;
        end
        if (s1_fire)
        begin
            delay_reg <= delay_next;
            pos_reg   <= pos_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign delay_us          = delay_reg;
    assign audio_position_us = pos_reg;

    // restart result is all zeros and leaves both streams unstarted
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_RESTART) |=>
            (out_valid && delay_us == '0 && audio_position_us == '0
             && !audio_started_reg && !video_started_reg && base_reg == STAMP_UNSET))
        else $error("restart did not clear clock state");

    // an audio transfer marks audio started and reports its own stamp
    a_audio_position: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_AUDIO) |=>
            (audio_started_reg && audio_position_us == last_audio_reg))
        else $error("audio position does not track last audio stamp");

    // the input register never drops an item while the output is blocked
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("pending item lost while output stalled");

endmodule

`default_nettype wire

### test/tb_av_sync_media_clock.sv
// tb_av_sync_media_clock: self-checking testbench for the a/v sync media clock
// depends on av_sync_pkg (stamp and opcode types) and av_sync_media_clock
module tb_av_sync_media_clock;
    timeunit 1ns;
    timeprecision 1ps;

    import av_sync_pkg::*;

    // code 3 has no member in the package enum; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam stamp_t STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};
    localparam stamp_t STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
    localparam stamp_t STAMP_ONES = '1;

    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int SESSIONS = 20;

    typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        stamp_t delay;
        stamp_t position;
    } clock_report_t;

    // one directed row; typed rows carry their expected report directly
    typedef struct packed {
        logic [1:0] op;
        stamp_t     stamp;
        stamp_t     wall;
        bit         typed;
        stamp_t     delay;
        stamp_t     position;
    } stim_row_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    logic   [1:0] opcode;
    stamp_t timestamp_us;
    stamp_t now_us;
    logic   out_valid;
    logic   out_stall;
    stamp_t delay_us;
    stamp_t audio_position_us;

    // reports the block still owes, oldest first
    clock_report_t reports_due[$];
    int            mismatches = 0;

    // shadow copy of the media clock state
    bit     audio_seen;
    bit     video_seen;
    stamp_t last_audio;
    stamp_t first_audio;
    stamp_t first_video;
    stamp_t base_time;

    // sender and receiver behavior, changed per phase
    bit       sender_steady = 1'b0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    bit       hold_req = 1'b0;

    // directed rows: reset, anchoring, catch-up of the base, zero base,
    // zero audio stamp, restart, unused code and the stamp extremes
    stim_row_t directed_rows [24] = '{
        // first audio after reset anchors the base and reports zero delay
        '{OP_AUDIO,   64'sd1000, 64'sd5000, 1'b1, 64'sd0, 64'sd1000},
        // video starts later with a larger first stamp: base is pulled back
        '{OP_VIDEO,   64'sd1500, 64'sd5600, 1'b0, 64'sd0, 64'sd0},
        '{OP_AUDIO,   64'sd2000, 64'sd6000, 1'b0, 64'sd0, 64'sd0},
        '{OP_VIDEO,   64'sd1600, 64'sd6100, 1'b0, 64'sd0, 64'sd0},
        '{OP_RESTART, 64'sd123,  64'sd456,  1'b1, 64'sd0, 64'sd0},
        '{OP_UNUSED,  64'sd77,   64'sd88,   1'b1, 64'sd0, 64'sd0},
        // video first with no audio: falls back to the elapsed media time
        '{OP_VIDEO,   64'sd7,    64'sd100,  1'b1, 64'sd0, 64'sd0},
        '{OP_VIDEO,   64'sd50,   64'sd200,  1'b0, 64'sd0, 64'sd0},
        // a zero audio stamp still counts as no audio
        '{OP_AUDIO,   64'sd0,    64'sd300,  1'b1, 64'sd0, 64'sd0},
        '{OP_VIDEO,   64'sd60,   64'sd310,  1'b0, 64'sd0, 64'sd0},
        '{OP_RESTART, 64'sd0,    64'sd0,    1'b1, 64'sd0, 64'sd0},
        // base computes to zero and stays unset, so video anchors it again
        '{OP_AUDIO,   64'sd500,  64'sd500,  1'b1, 64'sd0, 64'sd500},
        '{OP_VIDEO,   64'sd900,  64'sd600,  1'b0, 64'sd0, 64'sd0},
        '{OP_AUDIO,   64'sd600,  64'sd700,  1'b0, 64'sd0, 64'sd0},
        '{OP_RESTART, STAMP_MAX, STAMP_MIN, 1'b1, 64'sd0, 64'sd0},
        // extremes: subtractions that wrap modulo 2^64
        '{OP_AUDIO,   STAMP_MAX, STAMP_MIN, 1'b1, 64'sd0, STAMP_MAX},
        '{OP_AUDIO,   STAMP_MIN, STAMP_MAX, 1'b0, 64'sd0, 64'sd0},
        '{OP_VIDEO,   STAMP_MAX, STAMP_MIN, 1'b0, 64'sd0, 64'sd0},
        '{OP_UNUSED,  STAMP_MIN, STAMP_MAX, 1'b1, 64'sd0, STAMP_MIN},
        '{OP_RESTART, STAMP_ONES, STAMP_ONES, 1'b1, 64'sd0, 64'sd0},
        // base moved back to exactly zero after both streams started
        '{OP_AUDIO,   64'sd100,  64'sd150,  1'b1, 64'sd0, 64'sd100},
        '{OP_VIDEO,   64'sd150,  64'sd160,  1'b0, 64'sd0, 64'sd0},
        '{OP_AUDIO,   64'sd200,  64'sd400,  1'b0, 64'sd0, 64'sd0},
        '{OP_VIDEO,   STAMP_ONES, STAMP_ONES, 1'b0, 64'sd0, 64'sd0}
    };

    av_sync_media_clock i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .timestamp_us      (timestamp_us),
        .now_us            (now_us),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .delay_us          (delay_us),
        .audio_position_us (audio_position_us)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("tb_av_sync_media_clock NOT OK");
        $finish;
    end

    function automatic stamp_t rand_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic void clear_media_clock();
        audio_seen  = 1'b0;
        video_seen  = 1'b0;
        last_audio  = STAMP_UNSET;
        first_audio = STAMP_UNSET;
        first_video = STAMP_UNSET;
        base_time   = STAMP_UNSET;
    endfunction

    // advances the shadow clock by one update and returns the report it gives
    function automatic clock_report_t media_clock_step(input logic [1:0] op,
                                                       input stamp_t stamp,
                                                       input stamp_t wall);
        stamp_t media;
        clock_report_t rep;
        media = STAMP_UNSET;
        rep.delay = '0;
        case (op)
            OP_AUDIO:
            begin
                last_audio = stamp;
                if (!audio_seen)
                begin
                    audio_seen  = 1'b1;
                    first_audio = stamp;
                    media       = stamp;
                    if (base_time == STAMP_UNSET)
                        base_time = wall - stamp;
                    else if (first_audio > first_video)
                        base_time = base_time - (first_audio - first_video);
                end
                else
                    media = wall - base_time;
                rep.delay = last_audio - media;
            end
            OP_VIDEO:
            begin
                if (!video_seen)
                begin
                    video_seen  = 1'b1;
                    first_video = stamp;
                    media       = stamp;
                    if (base_time == STAMP_UNSET)
                        base_time = wall - stamp;
                    else if (first_video > first_audio)
                        base_time = base_time - (first_video - first_audio);
                end
                else
                    media = wall - base_time;
                // a zero audio stamp means no audio yet
                if (last_audio != STAMP_UNSET)
                    rep.delay = stamp - last_audio;
                else
                    rep.delay = stamp - media;
            end
            OP_RESTART:
                clear_media_clock();
            default:
                ;
        endcase
        rep.position = last_audio;
        return rep;
    endfunction

    function automatic void note_mismatch(input string what, input stamp_t want,
                                          input stamp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch on %s: expected %0d (%h) got %0d (%h)",
                     $realtime, what, want, want, got, got);
    endfunction

    // offers one update from a falling edge, holds it until the transfer,
    // then returns at the next falling edge; bursts and gaps are decided here
    task automatic send_update(input logic [1:0] op, input stamp_t stamp,
                               input stamp_t wall, input bit typed = 1'b0,
                               input clock_report_t typed_rep = '0);
        int gap;
        clock_report_t rep;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        opcode       <= op;
        timestamp_us <= stamp;
        now_us       <= wall;
        do
            @(posedge clk);
        while (in_stall);
        // transfer taken at this edge: the shadow clock moves along with it
        rep = media_clock_step(op, stamp, wall);
        reports_due.push_back(typed ? typed_rep : rep);
        @(negedge clk);
    endtask

    // sender pauses until every owed report has come back
    task automatic drain_reports();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (reports_due.size() != 0);
    endtask

    // one playback session: mostly a restart followed by interleaved audio
    // and video stamps that move forward, with some noise mixed in
    task automatic play_session(input int count);
        stamp_t audio_ts;
        stamp_t video_ts;
        stamp_t wall;
        stamp_t stamp;
        stamp_t now_val;
        logic [1:0] op;
        bit wild;
        int pick;
        if ($urandom_range(0, 4) != 0)
            send_update(OP_RESTART, rand_stamp(), rand_stamp());
        wild     = ($urandom_range(0, 5) == 0);
        audio_ts = stamp_t'($urandom_range(0, 100000));
        video_ts = audio_ts + stamp_t'($urandom_range(0, 2000)) - 64'sd1000;
        wall     = ($urandom_range(0, 3) == 0) ? rand_stamp() : stamp_t'($urandom);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            wall = wall + stamp_t'($urandom_range(1, 40000));
            now_val = wall;
            if (pick < 45)
            begin
                op = OP_AUDIO;
                audio_ts = audio_ts + stamp_t'($urandom_range(1, 30000));
                // now and then a zero stamp, which reads as no audio
                stamp = ($urandom_range(0, 29) == 0) ? STAMP_UNSET : audio_ts;
            end
            else if (pick < 90)
            begin
                op = OP_VIDEO;
                video_ts = video_ts + stamp_t'($urandom_range(1, 30000));
                stamp = video_ts;
            end
            else if (pick < 95)
            begin
                op = OP_UNUSED;
                stamp = rand_stamp();
                now_val = rand_stamp();
            end
            else
            begin
                op = OP_RESTART;
                stamp = rand_stamp();
                now_val = rand_stamp();
            end
            if (wild)
            begin
                stamp = rand_stamp();
                now_val = rand_stamp();
            end
            // first stamp with the wall equal to it leaves the base unset
            if (base_time == STAMP_UNSET && $urandom_range(0, 3) == 0)
                now_val = stamp;
            send_update(op, stamp, now_val);
        end
    endtask

    // receiver: long hold on request, otherwise free, random or patterned
    initial
    begin : receiver
        int hold_left;
        int phase;
        logic [6:0] rx_pattern;
        out_stall = 1'b0;
        hold_left = 0;
        phase = 0;
        rx_pattern = 7'b0110100;
        forever
        begin
            @(negedge clk);
            phase = (phase + 1) % 7;
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                case (rx_mode)
                    RX_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
                    RX_PATTERN: out_stall <= rx_pattern[phase[2:0]];
                    default:    out_stall <= 1'b0;
                endcase
        end
    end

    // result checker: every output transfer against the oldest owed report
    always @(posedge clk)
    begin : check_reports
        clock_report_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_due.size() == 0)
                note_mismatch("unexpected result delay_us", '0, delay_us);
            else
            begin
                due = reports_due.pop_front();
                if (delay_us !== due.delay)
                    note_mismatch("delay_us", due.delay, delay_us);
                if (audio_position_us !== due.position)
                    note_mismatch("audio_position_us", due.position, audio_position_us);
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_AUDIO;
        timestamp_us = '0;
        now_us       = '0;
        clear_media_clock();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, with the receiver busy at random
        rx_mode = RX_RANDOM;
        foreach (directed_rows[r])
            send_update(directed_rows[r].op, directed_rows[r].stamp,
                        directed_rows[r].wall, directed_rows[r].typed,
                        '{directed_rows[r].delay, directed_rows[r].position});
        drain_reports();

        // random sessions; the phase picks sender and receiver behavior
        for (int s = 0; s < SESSIONS; s++)
        begin
            rx_mode = rx_mode_t'(s % 3);
            sender_steady = (s % 4 == 1);
            if (s == 4)
            begin
                // receiver holds off while the sender keeps offering
                sender_steady = 1'b1;
                rx_mode = RX_FREE;
                hold_req = 1'b1;
            end
            if (s == 7 || s == 13)
                drain_reports();
            play_session($urandom_range(20, 40));
        end

        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge clk);
        // wait out DRAIN_CYCLES so a stray result would still be caught
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("tb_av_sync_media_clock OK");
        else
            $display("tb_av_sync_media_clock NOT OK");
        $finish;
    end

endmodule

### av_sync_media_clock.f
rtl/av_sync_pkg.sv
rtl/av_sync_media_clock.sv
test/tb_av_sync_media_clock.sv
